// File: hw/rtl/dbpc_pkg.sv
// dbpc_pkg: shared types and constants for the dual button press classifier
// operation codes, event kinds, register indexes and field widths
// no dependencies
`default_nettype none

package dbpc_pkg;

    // counter width of the press and tap totals, 8 to 32
    localparam int COUNT_WIDTH = 32;

    localparam int TIME_W  = 32;
    localparam int THR_W   = 16;
    localparam int KIND_W  = 3;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 168;
    localparam int M_TUSER_W = 4;

    // item operation
    typedef enum logic [1:0] {
        OP_POWER = 2'd0,
        OP_BOOT  = 2'd1,
        OP_ARM   = 2'd2
    } op_t;

    // classified event kinds
    typedef enum logic [KIND_W-1:0] {
        EV_PWR_GLITCH   = 3'd0,
        EV_PWR_INTERVAL = 3'd1,
        EV_BOOT_STARTUP = 3'd2,
        EV_BOOT_GLITCH  = 3'd3,
        EV_BOOT_LONG    = 3'd4,
        EV_BOOT_TAP     = 3'd5
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        REG_ACTIVE_LEVEL = 2'd0,
        REG_DEBOUNCE_MS  = 2'd1,
        REG_TAP_MAX_MS   = 2'd2
    } reg_idx_t;

    localparam logic [THR_W-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [THR_W-1:0] TAP_MAX_RESET  = 16'd500;

    // one result item
    typedef struct packed {
        logic                   event_valid;
        logic [KIND_W-1:0]      event_kind;
        logic [TIME_W-1:0]      duration;
        logic [TIME_W-1:0]      event_time;
        logic                   power_held;
        logic [TIME_W-1:0]      power_held_time;
        logic [COUNT_WIDTH-1:0] power_press_total;
        logic [COUNT_WIDTH-1:0] boot_tap_total;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/dual_button_press_classifier.sv
// dual_button_press_classifier: top level, press interval classifier for power and boot pins
// depends on dbpc_pkg
`default_nettype none

// Takes one item per clock cycle unless m_tready holds the result register: an input register
// holds the item, one pass of combinational logic (a 32-bit subtraction per pin, one more for
// the power hold time, three threshold compares) classifies it against the pin state, and the
// result register presents it on the master side. Every item gives exactly one result. s_tready
// stays high while the result register is empty or being taken. Configuration writes go straight
// to the registers; the user must make them only while no item is in flight (not enforced here).
module dual_button_press_classifier (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [dbpc_pkg::CFG_A_W-1:0]  cfg_addr,
    input  wire logic [dbpc_pkg::CFG_D_W-1:0]  cfg_wr_data,
    // input items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dbpc_pkg::S_TDATA_W-1:0] s_tdata,  // level[0], now_ms[32:1], zero pad
    input  wire logic [dbpc_pkg::S_TUSER_W-1:0] s_tuser,  // operation[1:0]
    // result items
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // duration[31:0], event_time[63:32], power_held[64], power_held_time[96:65],
    // power_press_total[128:97], boot_tap_total[160:129], zero pad
    output logic [dbpc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [dbpc_pkg::M_TUSER_W-1:0]     m_tuser   // event_valid[0], event_kind[3:1]
);

    localparam int TW = dbpc_pkg::TIME_W;
    localparam int CW = dbpc_pkg::COUNT_WIDTH;

    // configuration registers
    logic                       active_level_reg;
    logic [dbpc_pkg::THR_W-1:0] debounce_ms_reg;
    logic [dbpc_pkg::THR_W-1:0] tap_max_ms_reg;

    // input stage
    logic                       in_valid_reg;
    dbpc_pkg::op_t              in_op_reg;
    logic                       in_level_reg;
    logic [TW-1:0]              in_now_reg;

    // pin state
    logic                       power_open_reg, power_open_next;
    logic [TW-1:0]              power_start_reg, power_start_next;
    logic                       boot_open_reg, boot_open_next;
    logic [TW-1:0]              boot_start_reg, boot_start_next;
    logic                       armed_reg, armed_next;
    logic                       held_startup_reg, held_startup_next;
    logic [CW-1:0]              power_count_reg, power_count_next;
    logic [CW-1:0]              tap_count_reg, tap_count_next;

    // result stage
    logic                       out_valid_reg;
    dbpc_pkg::result_t          out_reg, out_next;

    logic                       advance;
    logic                       act;
    logic [TW-1:0]              power_dur;
    logic [TW-1:0]              boot_dur;
    logic                       ev_valid;
    dbpc_pkg::kind_t            ev_kind;
    logic [TW-1:0]              ev_dur;

    // handshake: the input stage moves whenever the result register is free
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg <= 1'b0;
            debounce_ms_reg  <= dbpc_pkg::DEBOUNCE_RESET;
            tap_max_ms_reg   <= dbpc_pkg::TAP_MAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dbpc_pkg::REG_ACTIVE_LEVEL: active_level_reg <= cfg_wr_data[0];
                dbpc_pkg::REG_DEBOUNCE_MS:  debounce_ms_reg  <= cfg_wr_data;
                dbpc_pkg::REG_TAP_MAX_MS:   tap_max_ms_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= dbpc_pkg::op_t'(s_tuser[1:0]);
            in_level_reg <= s_tdata[0];
            in_now_reg   <= s_tdata[TW:1];
        end
    end

    // classification of the item in the input register
    always_comb begin
        act               = (in_level_reg == active_level_reg);
        power_dur         = in_now_reg - power_start_reg;
        boot_dur          = in_now_reg - boot_start_reg;
        power_open_next   = power_open_reg;
        power_start_next  = power_start_reg;
        boot_open_next    = boot_open_reg;
        boot_start_next   = boot_start_reg;
        armed_next        = armed_reg;
        held_startup_next = held_startup_reg;
        power_count_next  = power_count_reg;
        tap_count_next    = tap_count_reg;
        ev_valid          = 1'b0;
        ev_kind           = dbpc_pkg::EV_PWR_GLITCH;
        ev_dur            = '0;

        case (in_op_reg)
            dbpc_pkg::OP_POWER: begin
                if (act) begin
                    if (!power_open_reg) begin
                        power_open_next  = 1'b1;
                        power_start_next = in_now_reg;
                    end
                end else if (power_open_reg) begin
                    power_open_next = 1'b0;
                    ev_valid        = 1'b1;
                    ev_dur          = power_dur;
                    if (power_dur < TW'(debounce_ms_reg)) begin
                        ev_kind = dbpc_pkg::EV_PWR_GLITCH;
                    end else begin
                        ev_kind          = dbpc_pkg::EV_PWR_INTERVAL;
                        power_count_next = power_count_reg + CW'(1);
                    end
                end
            end
            dbpc_pkg::OP_BOOT: begin
                if (!armed_reg) begin
                    // before arming every sample reports as startup suppressed
                    boot_open_next = act;
                    if (act) begin
                        boot_start_next = in_now_reg;
                    end
                    ev_valid = 1'b1;
                    ev_kind  = dbpc_pkg::EV_BOOT_STARTUP;
                end else if (act) begin
                    if (!boot_open_reg) begin
                        boot_open_next  = 1'b1;
                        boot_start_next = in_now_reg;
                    end
                end else if (boot_open_reg) begin
                    boot_open_next = 1'b0;
                    ev_valid       = 1'b1;
                    ev_dur         = boot_dur;
                    if (held_startup_reg) begin
                        held_startup_next = 1'b0;
                        ev_kind           = dbpc_pkg::EV_BOOT_STARTUP;
                    end else if (boot_dur < TW'(debounce_ms_reg)) begin
                        ev_kind = dbpc_pkg::EV_BOOT_GLITCH;
                    end else if (boot_dur >= TW'(tap_max_ms_reg)) begin
                        ev_kind = dbpc_pkg::EV_BOOT_LONG;
                    end else begin
                        ev_kind        = dbpc_pkg::EV_BOOT_TAP;
                        tap_count_next = tap_count_reg + CW'(1);
                    end
                end
            end
            dbpc_pkg::OP_ARM: begin
                armed_next        = 1'b1;
                held_startup_next = act;
                boot_open_next    = act;
                boot_start_next   = in_now_reg;
            end
            default: ;
        endcase

        // result item, power hold status taken after the update
        out_next.event_valid       = ev_valid;
        out_next.event_kind        = ev_valid ? ev_kind : dbpc_pkg::EV_PWR_GLITCH;
        out_next.duration          = ev_dur;
        out_next.event_time        = ev_valid ? in_now_reg : '0;
        out_next.power_held        = power_open_next;
        out_next.power_held_time   = power_open_next ? (in_now_reg - power_start_next) : '0;
        out_next.power_press_total = power_count_next;
        out_next.boot_tap_total    = tap_count_next;
    end

    // pin state update, once per item leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_open_reg   <= 1'b0;
            power_start_reg  <= '0;
            boot_open_reg    <= 1'b0;
            boot_start_reg   <= '0;
            armed_reg        <= 1'b0;
            held_startup_reg <= 1'b0;
            power_count_reg  <= '0;
            tap_count_reg    <= '0;
        end else if (in_valid_reg && advance) begin
            power_open_reg   <= power_open_next;
            power_start_reg  <= power_start_next;
            boot_open_reg    <= boot_open_next;
            boot_start_reg   <= boot_start_next;
            armed_reg        <= armed_next;
            held_startup_reg <= held_startup_next;
            power_count_reg  <= power_count_next;
            tap_count_reg    <= tap_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_reg <= out_next;
        end
    end

    // master side packing
    assign m_tuser = {out_reg.event_kind, out_reg.event_valid};
    assign m_tdata = {7'd0,
                      TW'(out_reg.boot_tap_total),
                      TW'(out_reg.power_press_total),
                      out_reg.power_held_time,
                      out_reg.power_held,
                      out_reg.event_time,
                      out_reg.duration};

endmodule

`default_nettype wire
